FILE: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic [1:0]         branch;
        logic               invalid;
    } t_out_word;

    // sideband that travels with an item through the root and divider stages
    typedef struct packed {
        logic [1:0]         branch;
        logic               invalid;
        logic signed [16:0] n0;
        logic signed [16:0] n1;
        logic signed [16:0] n2;
    } t_side;

endpackage

`default_nettype wire

FILE: rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Trace test, branch choice, root argument and off-diagonal numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ARG_W     = 18
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_in_word         i_data,
    output logic                  o_valid,
    output logic [ARG_W-1:0]      o_arg,
    output t_side                 o_side
);

    localparam int CW = ARG_W + 2;

    logic                  r_valid;
    logic [ARG_W-1:0]      r_arg, n_arg;
    t_side                 r_side, n_side;

    logic signed [CW-1:0]  e00, e11, e22, trace, one, sel_i, sel_j, sel_k, arg;
    logic [1:0]            br;

    always_comb begin
        e00   = CW'(i_data.m00);
        e11   = CW'(i_data.m11);
        e22   = CW'(i_data.m22);
        one   = CW'(1) <<< FRAC_BITS;
        trace = e00 + e11 + e22;
        if (trace > 0) begin
            br = BR_TRACE;
        end else if (i_data.m00 < i_data.m11) begin
            br = (i_data.m11 < i_data.m22) ? BR_Z : BR_Y;
        end else begin
            br = (i_data.m00 < i_data.m22) ? BR_Z : BR_X;
        end
        sel_i = e00;
        sel_j = e11;
        sel_k = e22;
        n_side.branch = br;
        n_side.n0 = 17'(i_data.m21) - 17'(i_data.m12);
        n_side.n1 = 17'(i_data.m02) - 17'(i_data.m20);
        n_side.n2 = 17'(i_data.m10) - 17'(i_data.m01);
        case (br)
            BR_X: begin
                sel_i = e00; sel_j = e11; sel_k = e22;
                n_side.n0 = 17'(i_data.m21) - 17'(i_data.m12);
                n_side.n1 = 17'(i_data.m10) + 17'(i_data.m01);
                n_side.n2 = 17'(i_data.m20) + 17'(i_data.m02);
            end
            BR_Y: begin
                sel_i = e11; sel_j = e22; sel_k = e00;
                n_side.n0 = 17'(i_data.m02) - 17'(i_data.m20);
                n_side.n1 = 17'(i_data.m21) + 17'(i_data.m12);
                n_side.n2 = 17'(i_data.m01) + 17'(i_data.m10);
            end
            BR_Z: begin
                sel_i = e22; sel_j = e00; sel_k = e11;
                n_side.n0 = 17'(i_data.m10) - 17'(i_data.m01);
                n_side.n1 = 17'(i_data.m02) + 17'(i_data.m20);
                n_side.n2 = 17'(i_data.m12) + 17'(i_data.m21);
            end
            default: begin
                sel_i = e00; sel_j = e11; sel_k = e22;
            end
        endcase
        if (br == BR_TRACE) begin
            arg = trace + one;
        end else begin
            arg = sel_i - sel_j - sel_k + one;
        end
        n_side.invalid = (arg <= 0);
        // keep the root well defined on a bad word, result is zeroed later
        n_arg = n_side.invalid ? ARG_W'(1) : arg[ARG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arg  <= n_arg;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_arg   = r_arg;
    assign o_side  = r_side;

endmodule

`default_nettype wire

FILE: rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Integer square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ARG_W     = 18,
    parameter int HW        = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [ARG_W-1:0] i_arg,
    input  wire t_side         i_side,
    output logic               o_valid,
    output logic [HW-1:0]      o_root,
    output t_side              o_side
);

    localparam int RW  = 2 * HW;
    localparam int RMW = HW + 2;

    logic [RW-1:0]  w_rad0;
    logic [RMW-1:0] r_rem  [HW];
    logic [RMW-1:0] n_rem  [HW];
    logic [HW-1:0]  r_root [HW];
    logic [HW-1:0]  n_root [HW];
    logic [RW-1:0]  r_rad  [HW];
    logic [RW-1:0]  n_rad  [HW];
    t_side          r_side [HW];
    t_side          n_side [HW];
    logic [HW-1:0]  r_v;
    logic [HW-1:0]  n_v;

    assign w_rad0 = {{(RW-ARG_W){1'b0}}, i_arg} << (FRAC_BITS - 2);

    genvar s;
    for (s = 0; s < HW; s++) begin : g_st
        logic [RMW-1:0] p_rem;
        logic [HW-1:0]  p_root;
        logic [RW-1:0]  p_rad;
        logic [RMW+1:0] cur;
        logic [RMW+1:0] trial;
        logic           ge;
        if (s == 0) begin : g_first
            assign p_rem     = '0;
            assign p_root    = '0;
            assign p_rad     = w_rad0;
            assign n_v[s]    = i_valid;
            assign n_side[s] = i_side;
        end else begin : g_next
            assign p_rem     = r_rem[s-1];
            assign p_root    = r_root[s-1];
            assign p_rad     = r_rad[s-1];
            assign n_v[s]    = r_v[s-1];
            assign n_side[s] = r_side[s-1];
        end
        assign cur       = {p_rem, p_rad[RW-1 -: 2]};
        assign trial     = {2'b00, p_root, 2'b01};
        assign ge        = (cur >= trial);
        assign n_rem[s]  = ge ? RMW'(cur - trial) : RMW'(cur);
        assign n_root[s] = {p_root[HW-2:0], ge};
        assign n_rad[s]  = {p_rad[RW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < HW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_v[HW-1];
    assign o_root  = r_root[HW-1];
    assign o_side  = r_side[HW-1];

endmodule

`default_nettype wire

FILE: rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Three restoring dividers side by side, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int HW        = 15,
    parameter int NW        = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [HW-1:0] i_root,
    input  wire t_side       i_side,
    output logic             o_valid,
    output logic [HW-1:0]    o_root,
    output logic [NW-1:0]    o_q [3],
    output t_side            o_side
);

    localparam int DW = HW + 2;

    logic [NW-1:0] w_num0 [3];
    logic [16:0]   w_n    [3];
    logic [DW-1:0] w_den;

    logic [DW-1:0] r_rem  [NW][3];
    logic [DW-1:0] n_rem  [NW][3];
    logic [NW-1:0] r_num  [NW][3];
    logic [NW-1:0] n_num  [NW][3];
    logic [NW-1:0] r_q    [NW][3];
    logic [NW-1:0] n_q    [NW][3];
    logic [HW-1:0] r_root [NW];
    logic [HW-1:0] n_root [NW];
    t_side         r_side [NW];
    t_side         n_side [NW];
    logic [NW-1:0] r_v;
    logic [NW-1:0] n_v;

    assign w_den = {i_root, 2'b00};
    assign w_n[0] = i_side.n0;
    assign w_n[1] = i_side.n1;
    assign w_n[2] = i_side.n2;

    genvar s, l;
    for (l = 0; l < 3; l++) begin : g_in
        logic [16:0] mag;
        // magnitude shifted up, plus half the divisor for rounding
        assign mag       = w_n[l][16] ? 17'(-w_n[l]) : w_n[l];
        assign w_num0[l] = (NW'(mag) << FRAC_BITS) + NW'({i_root, 1'b0});
    end

    for (s = 0; s < NW; s++) begin : g_st
        if (s == 0) begin : g_first
            assign n_v[s]    = i_valid;
            assign n_root[s] = i_root;
            assign n_side[s] = i_side;
        end else begin : g_next
            assign n_v[s]    = r_v[s-1];
            assign n_root[s] = r_root[s-1];
            assign n_side[s] = r_side[s-1];
        end
        for (l = 0; l < 3; l++) begin : g_lane
            logic [DW-1:0] p_rem;
            logic [NW-1:0] p_num;
            logic [NW-1:0] p_q;
            logic [DW-1:0] p_den;
            logic [DW:0]   cur;
            logic          ge;
            if (s == 0) begin : g_first
                assign p_rem = '0;
                assign p_num = w_num0[l];
                assign p_q   = '0;
                assign p_den = w_den;
            end else begin : g_next
                assign p_rem = r_rem[s-1][l];
                assign p_num = r_num[s-1][l];
                assign p_q   = r_q[s-1][l];
                assign p_den = {r_root[s-1], 2'b00};
            end
            assign cur         = {p_rem, p_num[NW-1]};
            assign ge          = (cur >= {1'b0, p_den});
            assign n_rem[s][l] = ge ? DW'(cur - {1'b0, p_den}) : DW'(cur);
            assign n_num[s][l] = {p_num[NW-2:0], 1'b0};
            assign n_q[s][l]   = {p_q[NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_root[k] <= n_root[k];
                r_side[k] <= n_side[k];
                for (int j = 0; j < 3; j++) begin
                    r_rem[k][j] <= n_rem[k][j];
                    r_num[k][j] <= n_num[k][j];
                    r_q[k][j]   <= n_q[k][j];
                end
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_root  = r_root[NW-1];
    assign o_side  = r_side[NW-1];
    assign o_q[0]  = r_q[NW-1][0];
    assign o_q[1]  = r_q[NW-1][1];
    assign o_q[2]  = r_q[NW-1][2];

endmodule

`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion, Shepperd's method, fixed point pipeline.
// ----------------------------------------------------------------------------
//  channel   valid     stall     word
//  input     i_valid   o_stall   i_data  (t_in_word, nine matrix entries)
//  output    o_valid   i_stall   o_data  (t_out_word, quaternion and flags)
//
//  one word per cycle while i_stall does not hold an output word; stages:
//  front stage, one stage per root bit (HW), one stage per quotient bit (NW),
//  output register
//  synchronous active-low reset clears every valid bit
//  a held output word freezes the whole pipeline, so o_stall follows it
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_word  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_data
);

    localparam int ARG_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int RW0   = ARG_W + FRAC_BITS - 2;
    localparam int HW    = (RW0 + 1) / 2;
    localparam int NW    = FRAC_BITS + 18;

    logic             en;
    logic             f_valid, s_valid, d_valid;
    logic [ARG_W-1:0] f_arg;
    t_side            f_side, s_side, d_side;
    logic [HW-1:0]    s_root, d_root;
    logic [NW-1:0]    d_q [3];
    logic signed [15:0] c [3];
    logic signed [15:0] hs;
    logic [16:0]      d_n [3];

    logic             r_valid;
    t_out_word        r_data, n_data;

    assign en      = !(r_valid && i_stall);
    assign o_stall = r_valid && i_stall;

    rmq_front #(.FRAC_BITS(FRAC_BITS), .ARG_W(ARG_W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (f_valid),
        .o_arg   (f_arg),
        .o_side  (f_side)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .ARG_W(ARG_W), .HW(HW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_arg   (f_arg),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .HW(HW), .NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_side  (s_side),
        .o_valid (d_valid),
        .o_root  (d_root),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    function automatic logic signed [15:0] sat_q(input logic [NW-1:0] q, input logic neg);
        logic signed [15:0] res;
        if (neg) begin
            res = (q >= NW'(32768)) ? 16'sh8000 : 16'(~q[15:0] + 16'd1);
        end else begin
            res = (q >= NW'(32767)) ? 16'sh7fff : 16'(q[15:0]);
        end
        return res;
    endfunction

    assign d_n[0] = d_side.n0;
    assign d_n[1] = d_side.n1;
    assign d_n[2] = d_side.n2;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            c[l] = sat_q(d_q[l], d_n[l][16]);
        end
        hs = (d_root >= HW'(32767)) ? 16'sh7fff : 16'(d_root);
        n_data.branch  = d_side.branch;
        n_data.invalid = d_side.invalid;
        case (d_side.branch)
            BR_TRACE: begin
                n_data.qx = c[0]; n_data.qy = c[1]; n_data.qz = c[2]; n_data.qw = hs;
            end
            BR_X: begin
                n_data.qx = hs; n_data.qy = c[1]; n_data.qz = c[2]; n_data.qw = c[0];
            end
            BR_Y: begin
                n_data.qx = c[2]; n_data.qy = hs; n_data.qz = c[1]; n_data.qw = c[0];
            end
            BR_Z: begin
                n_data.qx = c[1]; n_data.qy = c[2]; n_data.qz = hs; n_data.qw = c[0];
            end
            default: begin
                n_data.qx = c[0]; n_data.qy = c[1]; n_data.qz = c[2]; n_data.qw = hs;
            end
        endcase
        if (d_side.invalid) begin
            n_data.qx = '0;
            n_data.qy = '0;
            n_data.qz = '0;
            n_data.qw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.invalid |->
            o_data.qx == 0 && o_data.qy == 0 && o_data.qz == 0 && o_data.qw == 0)
        else $error("invalid word with nonzero components");
    a_invalid_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.invalid |-> o_data.branch != BR_TRACE)
        else $error("invalid flag on trace branch");
    a_trace_w_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.branch == BR_TRACE |-> !o_data.qw[15] && o_data.qw != 0)
        else $error("trace branch scalar not positive");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(f_side) && $stable(f_valid) && $stable(d_side))
        else $error("pipeline moved while frozen");
`endif

endmodule

`default_nettype wire

FILE: test/rotation_matrix_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives matrices through the quaternion pipeline with random gaps and stalls
// and checks every output word against a predictor of Shepperd's method.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class quat_scoreboard;
    rmq_pkg::t_out_word pending[$];
    int errors = 0;

    static function longint isqrt(longint v);
        longint res, bit_v;
        res = 0;
        bit_v = 64'sd1 << 62;
        while (bit_v > v) bit_v = bit_v >>> 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v = v - (res + bit_v);
                res = (res >>> 1) + bit_v;
            end else begin
                res = res >>> 1;
            end
            bit_v = bit_v >>> 2;
        end
        return res;
    endfunction

    static function logic [15:0] clip(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    static function logic [15:0] ratio(longint n, longint h);
        longint mag, den, q;
        mag = (n < 0) ? -n : n;
        den = h * 4;
        q = ((mag << 14) + den / 2) / den;
        if (q > 65536) q = 65536;
        return clip(n < 0 ? -q : q);
    endfunction

    function void note_matrix(rmq_pkg::t_in_word w);
        longint m[3][3];
        longint q[4];
        longint tr, arg, h;
        int i, j, k;
        rmq_pkg::t_out_word r;
        m[0][0] = w.m00; m[0][1] = w.m01; m[0][2] = w.m02;
        m[1][0] = w.m10; m[1][1] = w.m11; m[1][2] = w.m12;
        m[2][0] = w.m20; m[2][1] = w.m21; m[2][2] = w.m22;
        for (int c = 0; c < 4; c++) q[c] = 0;
        r = '0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            r.branch = rmq_pkg::BR_TRACE;
            h = isqrt((tr + 16384) << 12);
            q[3] = clip(h);
            q[0] = ratio(m[2][1] - m[1][2], h);
            q[1] = ratio(m[0][2] - m[2][0], h);
            q[2] = ratio(m[1][0] - m[0][1], h);
        end else begin
            if (m[0][0] < m[1][1]) i = (m[1][1] < m[2][2]) ? 2 : 1;
            else i = (m[0][0] < m[2][2]) ? 2 : 0;
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            r.branch = (i == 0) ? rmq_pkg::BR_X : (i == 1) ? rmq_pkg::BR_Y : rmq_pkg::BR_Z;
            arg = m[i][i] - m[j][j] - m[k][k] + 16384;
            if (arg <= 0) begin
                r.invalid = 1'b1;
            end else begin
                h = isqrt(arg << 12);
                q[i] = clip(h);
                q[3] = ratio(m[k][j] - m[j][k], h);
                q[j] = ratio(m[j][i] + m[i][j], h);
                q[k] = ratio(m[k][i] + m[i][k], h);
            end
        end
        r.qx = q[0][15:0]; r.qy = q[1][15:0]; r.qz = q[2][15:0]; r.qw = q[3][15:0];
        pending.push_back(r);
    endfunction

    function void check_quat(rmq_pkg::t_out_word got);
        rmq_pkg::t_out_word exp_w;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
            return;
        end
        exp_w = pending.pop_front();
        if (got.qx !== exp_w.qx)
            $display("%0t: qx exp %0d got %0d", $time, exp_w.qx, got.qx);
        if (got.qy !== exp_w.qy)
            $display("%0t: qy exp %0d got %0d", $time, exp_w.qy, got.qy);
        if (got.qz !== exp_w.qz)
            $display("%0t: qz exp %0d got %0d", $time, exp_w.qz, got.qz);
        if (got.qw !== exp_w.qw)
            $display("%0t: qw exp %0d got %0d", $time, exp_w.qw, got.qw);
        if (got.branch !== exp_w.branch)
            $display("%0t: branch exp %0d got %0d", $time, exp_w.branch, got.branch);
        if (got.invalid !== exp_w.invalid)
            $display("%0t: invalid exp %0d got %0d", $time, exp_w.invalid, got.invalid);
        if (got !== exp_w) errors++;
    endfunction
endclass

module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    localparam int LATENCY = 49;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic signed [15:0] ONE = 16'sd16384;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in_word i_data = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    t_out_word o_data;

    quat_scoreboard sb = new();
    bit long_hold = 1'b0;
    bit rx_enable = 1'b0;
    int idle_cycles = 0;

    rotation_matrix_to_quaternion u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_matrix(i_data);
        if (i_rst_n && o_valid && !i_stall) sb.check_quat(o_data);
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stall per word, plus a long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk);
        wait (rx_enable);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    task automatic send_word(t_in_word w, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_diag(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c, bit burst);
        t_in_word w;
        w = '0;
        w.m00 = a; w.m11 = b; w.m22 = c;
        w.m01 = 16'($urandom); w.m02 = 16'($urandom); w.m10 = 16'($urandom);
        w.m12 = 16'($urandom); w.m20 = 16'($urandom); w.m21 = 16'($urandom);
        send_word(w, burst);
    endtask

    function automatic logic signed [15:0] small_entry();
        return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endfunction

    task automatic send_random(bit burst);
        t_in_word w;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            // random entries in [-1, 1]
            w.m00 = small_entry(); w.m01 = small_entry(); w.m02 = small_entry();
            w.m10 = small_entry(); w.m11 = small_entry(); w.m12 = small_entry();
            w.m20 = small_entry(); w.m21 = small_entry(); w.m22 = small_entry();
            if (kind == 5) begin
                w.m00 = -w.m11;
                w.m22 = w.m22 >>> 1;
            end
            send_word(w, burst);
        end else begin
            w = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
            send_word(w, burst);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_in_word w;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_enable = 1'b1;

        // directed: identity diagonal, each branch, ties, extremes
        send_diag(ONE, ONE, ONE, 0);
        send_diag(ONE, -ONE, -ONE, 0);
        send_diag(-ONE, ONE, -ONE, 0);
        send_diag(-ONE, -ONE, ONE, 0);
        send_diag(16'sd0, 16'sd0, 16'sd0, 0);
        send_diag(-16'sd5, -16'sd5, -16'sd5, 0);
        send_diag(-16'sd100, -16'sd100, 16'sd50, 0);
        send_diag(16'sd10, 16'sd10, -16'sd30, 0);
        send_diag(-16'sd32768, -16'sd32768, -16'sd32768, 0);
        send_diag(16'sd32767, 16'sd32767, 16'sd32767, 0);
        send_diag(16'sd32767, -16'sd32768, -16'sd32768, 0);
        send_diag(-16'sd32768, 16'sd1, -16'sd32768, 0);
        send_diag(-16'sd16384, -16'sd16384, -16'sd16384, 0);
        send_diag(16'sd1, -16'sd1, 16'sd0, 0);
        send_diag(16'sd0, 16'sd0, 16'sd1, 0);
        w = {9{16'sh7fff}};
        send_word(w, 0);
        w = {9{16'sh8000}};
        send_word(w, 0);
        w = '0;
        w.m00 = -16'sd16384; w.m11 = -16'sd16384; w.m22 = -16'sd16384;
        w.m01 = 16'sh7fff; w.m10 = 16'sh7fff; w.m21 = 16'sh8000; w.m12 = 16'sh7fff;
        send_word(w, 0);
        w = '0;
        w.m00 = 16'sd8; w.m21 = 16'sh7fff; w.m12 = 16'sh8000;
        send_word(w, 0);

        // pause until everything is back
        drain();

        for (int n = 0; n < 1530; n++) begin
            if (n == 400) long_hold = 1'b1;
            send_random(n >= 400 && n < 800 ? ($urandom_range(0, 3) != 0) : 1'b0);
        end

        drain();
        i_valid <= 1'b0;
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
